// File: rtl/swm_pkg.sv
// Shared constants for the sliding window maximum block.
package swm_pkg;

    // Default largest window length, in samples.
    localparam int MAX_WINDOW_DEF = 64;

    // Default sample width, in bits.
    localparam int SAMPLE_WIDTH_DEF = 16;

endpackage

// File: rtl/sliding_window_maximum.sv
// Top level of the sliding window maximum block: control, cell chain and result register.
//
// Channel   Handshake                   Payload
// -------   -------------------------   ---------------------------------
// sample    sample_valid / sample_stall sample_value (signed), restart
// result    max_valid / max_stall       window_max (signed)
// config    cfg_valid / cfg_ready       window_size
//
// The block takes one sample request per clock cycle while not stalled. The result of a
// sample appears in the output register on the cycle after the request is accepted; the
// only work per sample: one compare in each cell, a one-hot cell select, a final compare.
// Reset (rst_n, asynchronous, active low) clears the control state and sets the
// window length to one; no clearing pass is needed and requests are taken right away.
// A sample request stalls only while a result sits in the output register and the
// result side stalls it; a request that yields no result stalls the same way.
//
// Cell i of the chain holds the maximum of the last i+1 samples. A new sample moves
// every cell one step: cell i takes the larger of the sample and the old value of
// cell i-1. The maximum over a window of k samples is then the larger of the new
// sample and the old value of cell k-2, picked through a one-hot tap vector that is
// decoded when the window length is written. The cells need no clearing on a restart:
// a result is only sent once k samples have arrived since the last restart, and by
// then every sample that the picked cell covers is a fresh one. The same count, kept
// clamped to the window length, makes a change of the window length exact: after a
// larger window is written, results resume only once the larger window has filled.
module sliding_window_maximum #(
    parameter int MAX_WINDOW   = swm_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,

    // Window length configuration.
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [$clog2(MAX_WINDOW+1)-1:0] window_size,

    // Sample stream.
    input  logic                           sample_valid,
    output logic                           sample_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_value,
    input  logic                           restart,

    // Window maximum results.
    output logic                           max_valid,
    input  logic                           max_stall,
    output logic signed [SAMPLE_WIDTH-1:0] window_max
);

    // Width of a window length or sample count, able to hold MAX_WINDOW itself.
    localparam int WIN_W = $clog2(MAX_WINDOW + 1);
    // The result never reads the cell that covers MAX_WINDOW samples, so it is left out.
    localparam int NUM_CELLS = MAX_WINDOW - 1;

    localparam logic [WIN_W-1:0] WIN_MAX = WIN_W'(MAX_WINDOW);
    localparam logic [WIN_W-1:0] WIN_ONE = WIN_W'(1);

    // The leftmost cell sees the most negative value, so it simply loads the sample.
    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    // Configuration state.
    logic [WIN_W-1:0]     win_reg;
    logic [WIN_W-1:0]     win_next;
    logic [NUM_CELLS-1:0] tap_reg;
    logic [NUM_CELLS-1:0] tap_next;

    // Stream control state.
    logic [WIN_W-1:0]     seen_reg;
    logic [WIN_W-1:0]     seen_next;
    logic                 max_valid_reg;
    logic                 max_valid_next;
    logic signed [SAMPLE_WIDTH-1:0] window_max_reg;
    logic signed [SAMPLE_WIDTH-1:0] window_max_next;

    logic                 cfg_write;
    logic                 accept;
    logic                 win_zero;
    logic                 step;
    logic                 emit;
    logic [WIN_W-1:0]     seen_base;
    logic [WIN_W:0]       seen_inc;

    logic signed [SAMPLE_WIDTH-1:0] cell_value [NUM_CELLS];
    logic signed [SAMPLE_WIDTH-1:0] tap_value;

    // The window length register is always writable; writes must come only while idle.
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // A written length above the largest window saturates to it. The tap vector marks
    // the cell that covers one sample less than the window; it stays empty for a
    // window of one or zero samples.
    always_comb
    begin
        win_next = (window_size > WIN_MAX) ? WIN_MAX : window_size;
        for (int i = 0; i < NUM_CELLS; i++)
        begin
            tap_next[i] = (win_next == WIN_W'(i + 2));
        end
    end

    // A sample request is refused only while an undelivered result is held back.
    assign sample_stall = max_valid_reg && max_stall;
    assign accept       = sample_valid && !sample_stall;

    // With a zero window a sample is dropped and only its restart flag has effect.
    assign win_zero = (win_reg == '0);
    assign step     = accept && !win_zero;

    // Samples since the last restart, clamped to the window length.
    assign seen_base = restart ? '0 : seen_reg;
    assign seen_inc  = {1'b0, seen_base} + (WIN_W + 1)'(1);
    assign emit      = (seen_inc >= {1'b0, win_reg});

    always_comb
    begin
        seen_next = seen_reg;
        if (accept)
        begin
            if (win_zero)
            begin
                seen_next = seen_base;
            end
            else if (emit)
            begin
                seen_next = win_reg;
            end
            else
            begin
                seen_next = seen_inc[WIN_W-1:0];
            end
        end
    end

    // Chain of cells, each handing its maximum to the right neighbor on every sample.
    for (genvar g = 0; g < NUM_CELLS; g++)
    begin : g_cell
        logic signed [SAMPLE_WIDTH-1:0] left;

        if (g == 0)
        begin : g_first
            assign left = SAMPLE_MIN;
        end
        else
        begin : g_rest
            assign left = cell_value[g-1];
        end

        swm_cell #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH)
        ) u_cell (
            .clk    (clk),
            .shift  (step),
            .sample (sample_value),
            .left   (left),
            .value  (cell_value[g])
        );
    end

    // One-hot pick of the tapped cell's old value.
    always_comb
    begin
        tap_value = '0;
        for (int i = 0; i < NUM_CELLS; i++)
        begin
            tap_value = tap_value | (cell_value[i] & {SAMPLE_WIDTH{tap_reg[i]}});
        end
    end

    // The window maximum is the new sample against the maximum of the samples before it.
    always_comb
    begin
        if (win_reg == WIN_ONE)
        begin
            window_max_next = sample_value;
        end
        else
        begin
            window_max_next = (tap_value > sample_value) ? tap_value : sample_value;
        end
    end

    always_comb
    begin
        max_valid_next = max_valid_reg;
        if (step && emit)
        begin
            max_valid_next = 1'b1;
        end
        else if (max_valid_reg && !max_stall)
        begin
            max_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg       <= WIN_ONE;
            tap_reg       <= '0;
            seen_reg      <= '0;
            max_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                win_reg <= win_next;
                tap_reg <= tap_next;
            end
            seen_reg      <= seen_next;
            max_valid_reg <= max_valid_next;
        end
    end

    // The result payload is loaded only together with its valid flag.
    always_ff @(posedge clk)
    begin
        if (step && emit)
        begin
            window_max_reg <= window_max_next;
        end
    end

    assign max_valid  = max_valid_reg;
    assign window_max = window_max_reg;

endmodule

// File: rtl/swm_cell.sv
// One cell of the running maximum chain: holds the maximum of a fixed-length suffix of the stream.
module swm_cell #(
    parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           shift,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  logic signed [SAMPLE_WIDTH-1:0] left,
    output logic signed [SAMPLE_WIDTH-1:0] value
);

    logic signed [SAMPLE_WIDTH-1:0] value_reg;
    logic signed [SAMPLE_WIDTH-1:0] value_next;

    // The window of this cell is one sample longer than that of its left neighbor,
    // so its new maximum is the larger of the new sample and the neighbor's old one.
    assign value_next = (left > sample) ? left : sample;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            value_reg <= value_next;
        end
    end

    assign value = value_reg;

endmodule
